>>> src/ctm_pkg.sv
// Package holding the shared types and constants of the channel timeout monitor.
`timescale 1ns / 1ps

package ctm_pkg;

    localparam int MAX_CHANNELS = 4;
    localparam int CHAN_W       = 2;
    localparam int TIME_W       = 64;
    localparam int LIMIT_MS_W   = 16;
    localparam int STATUS_W     = 2;
    localparam int CFG_IDX_W    = 2;
    localparam int SCALE_W      = 20;

    localparam logic [SCALE_W-1:0] NS_PER_MS = 20'd1000000;

    // Request kinds.
    localparam logic REQ_ARRIVAL = 1'b0;
    localparam logic REQ_CHECK   = 1'b1;

    // Channel status codes.
    localparam logic [STATUS_W-1:0] ST_NORMAL  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_WARNING = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ERROR   = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WARN_LIM  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ERROR_LIM = 2'd2;

    typedef logic [TIME_W-1:0] time_t;

    // Control from the sequencer to the shared compare unit.
    typedef struct packed {
        logic                  lim_load;
        logic [LIMIT_MS_W-1:0] lim_ms;
    } unit_ctl_t;

endpackage

>>> src/ctm_intf.sv
// Interfaces for the request, result and configuration channels.
`timescale 1ns / 1ps

interface ctm_req_if;
    logic                       valid;
    logic                       ready;
    logic                       req_type;
    logic [ctm_pkg::CHAN_W-1:0] chan;
    ctm_pkg::time_t             time_ns;

    modport source (output valid, req_type, chan, time_ns, input ready);
    modport sink   (input valid, req_type, chan, time_ns, output ready);
endinterface

interface ctm_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [ctm_pkg::CHAN_W-1:0]   out_chan;
    logic [ctm_pkg::STATUS_W-1:0] status;
    logic                         changed;
    ctm_pkg::time_t               age_ns;
    logic                         enabled;
    logic                         last;

    modport source (output valid, out_chan, status, changed, age_ns, enabled, last,
                    input ready);
    modport sink   (input valid, out_chan, status, changed, age_ns, enabled, last,
                    output ready);
endinterface

interface ctm_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [ctm_pkg::CFG_IDX_W-1:0] index;
    logic [ctm_pkg::TIME_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> src/channel_timeout_monitor.sv
// Top level of the channel timeout monitor: state store, sequencer and result register.
`timescale 1ns / 1ps

// Heartbeat watchdog for up to four message channels.
// The req channel takes arrivals (req_type 0), which store a timestamp for one
// enabled channel and give no result, and checks (req_type 1), which carry the
// current time. Each check produces NUM_CHANNELS result beats on the rsp
// channel in channel order, the final one marked with last. The cfg channel
// writes the enable mask and the packed warning and error limits; it is always
// ready and should only be used while the block is idle.
// An arrival is handled in the idle state and the block is ready again at once. A check
// walks the channels one after another through a single 64-bit subtract and
// compare unit in the steps age, error compare, warning compare and result for a
// channel that has history; the warning compare is skipped when the error limit is
// hit, and a disabled or not yet seen channel goes straight to the result step.
// The req channel is not ready during a check.
// Results leave through a single output register; if the receiver stalls, the
// walk pauses at the result step until the register frees up.
// Reset clears the configuration, all per-channel history and the output valid flag.

module channel_timeout_monitor #(
    parameter int NUM_CHANNELS = 4
) (
    input  logic      clk,
    input  logic      rst_n,
    ctm_req_if.sink   req,
    ctm_rsp_if.source rsp,
    ctm_cfg_if.sink   cfg
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EVAL = 3'd1;
    localparam logic [2:0] S_ERR  = 3'd2;
    localparam logic [2:0] S_WARN = 3'd3;
    localparam logic [2:0] S_EMIT = 3'd4;

    localparam int CW = ctm_pkg::CHAN_W;
    localparam int SW = ctm_pkg::STATUS_W;
    localparam logic [CW-1:0] LAST_CH = CW'(NUM_CHANNELS - 1);

    // Configuration registers.
    logic [ctm_pkg::MAX_CHANNELS-1:0] enable_reg;
    ctm_pkg::time_t                   warn_reg;
    ctm_pkg::time_t                   error_reg;

    // Per-channel history.
    ctm_pkg::time_t last_seen_reg  [ctm_pkg::MAX_CHANNELS];
    ctm_pkg::time_t last_age_reg   [ctm_pkg::MAX_CHANNELS];
    logic [SW-1:0]  cur_state_reg  [ctm_pkg::MAX_CHANNELS];
    logic [SW-1:0]  prev_state_reg [ctm_pkg::MAX_CHANNELS];

    // Sequencer.
    logic [2:0]     state_reg;
    logic [2:0]     state_next;
    logic [CW-1:0]  ch_reg;
    logic [CW-1:0]  ch_next;
    ctm_pkg::time_t now_reg;

    // Output register.
    logic           out_valid_reg;
    logic [CW-1:0]  out_chan_reg;
    logic [SW-1:0]  out_status_reg;
    logic           out_changed_reg;
    ctm_pkg::time_t out_age_reg;
    logic           out_enabled_reg;
    logic           out_last_reg;

    logic               req_fire;
    logic               arr_on;
    logic               ch_on;
    logic               emit_go;
    logic               is_last;
    ctm_pkg::unit_ctl_t ctl;
    ctm_pkg::time_t     op_a;
    ctm_pkg::time_t     op_b;
    ctm_pkg::time_t     lim_ns;
    ctm_pkg::time_t     diff;
    logic               gt;

    assign req.ready = (state_reg == S_IDLE);
    assign req_fire  = req.valid && req.ready;
    assign cfg.ready = 1'b1;

    assign arr_on  = ({1'b0, req.chan} < (CW+1)'(NUM_CHANNELS)) && enable_reg[req.chan];
    assign ch_on   = enable_reg[ch_reg];
    assign is_last = (ch_reg == LAST_CH);
    assign emit_go = (state_reg == S_EMIT) && (!out_valid_reg || rsp.ready);

    // The error limit is scaled while the age is formed, the warning limit while
    // the age is compared against the error limit.
    always_comb
    begin
        ctl.lim_load = (state_reg == S_EVAL) || (state_reg == S_ERR);
        ctl.lim_ms   = (state_reg == S_EVAL)
                     ? error_reg[ch_reg*ctm_pkg::LIMIT_MS_W +: ctm_pkg::LIMIT_MS_W]
                     : warn_reg[ch_reg*ctm_pkg::LIMIT_MS_W +: ctm_pkg::LIMIT_MS_W];
        if (state_reg == S_EVAL)
        begin
            op_a = now_reg;
            op_b = last_seen_reg[ch_reg];
        end
        else
        begin
            op_a = last_age_reg[ch_reg];
            op_b = lim_ns;
        end
    end

    ctm_unit u_unit (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (ctl),
        .a      (op_a),
        .b      (op_b),
        .lim_ns (lim_ns),
        .diff   (diff),
        .gt     (gt)
    );

    always_comb
    begin
        state_next = state_reg;
        ch_next    = ch_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_fire && (req.req_type == ctm_pkg::REQ_CHECK))
                begin
                    state_next = S_EVAL;
                    ch_next    = '0;
                end
            end
            S_EVAL:
            begin
                if (ch_on && (last_seen_reg[ch_reg] != '0))
                begin
                    state_next = S_ERR;
                end
                else
                begin
                    state_next = S_EMIT;
                end
            end
            S_ERR:
            begin
                state_next = gt ? S_EMIT : S_WARN;
            end
            S_WARN:
            begin
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (emit_go)
                begin
                    if (is_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_EVAL;
                        ch_next    = ch_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ch_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ch_reg    <= ch_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            now_reg <= req.time_ns;
        end
    end

    // Configuration writes; indexes beyond the list are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= '0;
            warn_reg   <= '0;
            error_reg  <= '0;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                ctm_pkg::CFG_ENABLE:    enable_reg <= cfg.data[ctm_pkg::MAX_CHANNELS-1:0];
                ctm_pkg::CFG_WARN_LIM:  warn_reg   <= cfg.data;
                ctm_pkg::CFG_ERROR_LIM: error_reg  <= cfg.data;
                default:                ;
            endcase
        end
    end

    // History update. An unseen channel adopts the check time and keeps its status.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ctm_pkg::MAX_CHANNELS; i++)
            begin
                last_seen_reg[i]  <= '0;
                last_age_reg[i]   <= '0;
                cur_state_reg[i]  <= ctm_pkg::ST_NORMAL;
                prev_state_reg[i] <= ctm_pkg::ST_NORMAL;
            end
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (req_fire && (req.req_type == ctm_pkg::REQ_ARRIVAL) && arr_on)
                    begin
                        last_seen_reg[req.chan] <= req.time_ns;
                    end
                end
                S_EVAL:
                begin
                    if (ch_on)
                    begin
                        if (last_seen_reg[ch_reg] != '0)
                        begin
                            last_age_reg[ch_reg] <= gt ? diff : '0;
                        end
                        else
                        begin
                            last_seen_reg[ch_reg] <= now_reg;
                            last_age_reg[ch_reg]  <= '0;
                        end
                    end
                end
                S_ERR:
                begin
                    if (gt)
                    begin
                        prev_state_reg[ch_reg] <= cur_state_reg[ch_reg];
                        cur_state_reg[ch_reg]  <= ctm_pkg::ST_ERROR;
                    end
                end
                S_WARN:
                begin
                    prev_state_reg[ch_reg] <= cur_state_reg[ch_reg];
                    cur_state_reg[ch_reg]  <= gt ? ctm_pkg::ST_WARNING : ctm_pkg::ST_NORMAL;
                end
                default:
                begin
                end
            endcase
        end
    end

    // Result register: a disabled channel reports zeros apart from its index and last.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit_go)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_go)
        begin
            out_chan_reg    <= ch_reg;
            out_status_reg  <= ch_on ? cur_state_reg[ch_reg] : ctm_pkg::ST_NORMAL;
            out_changed_reg <= ch_on && (cur_state_reg[ch_reg] != prev_state_reg[ch_reg]);
            out_age_reg     <= ch_on ? last_age_reg[ch_reg] : '0;
            out_enabled_reg <= ch_on;
            out_last_reg    <= is_last;
        end
    end

    assign rsp.valid    = out_valid_reg;
    assign rsp.out_chan = out_chan_reg;
    assign rsp.status   = out_status_reg;
    assign rsp.changed  = out_changed_reg;
    assign rsp.age_ns   = out_age_reg;
    assign rsp.enabled  = out_enabled_reg;
    assign rsp.last     = out_last_reg;

    // A check always starts its walk at channel zero.
    a_check_start: assert property (@(posedge clk) disable iff (!rst_n)
        (req_fire && (req.req_type == ctm_pkg::REQ_CHECK)) |=>
            (state_reg == S_EVAL) && (ch_reg == '0))
        else $error("check did not start at channel zero");

    // The final result of a walk returns the sequencer to idle.
    a_walk_end: assert property (@(posedge clk) disable iff (!rst_n)
        (emit_go && is_last) |=> (state_reg == S_IDLE) && rsp.valid && rsp.last)
        else $error("walk did not finish after its last result");

    // A status code outside the defined three never leaves the block.
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> (rsp.status == ctm_pkg::ST_NORMAL) ||
                      (rsp.status == ctm_pkg::ST_WARNING) ||
                      (rsp.status == ctm_pkg::ST_ERROR))
        else $error("undefined status code on result");

    // A disabled channel reports nothing but its index and position.
    a_disabled_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.enabled) |->
            (rsp.age_ns == '0) && (rsp.status == ctm_pkg::ST_NORMAL) && !rsp.changed)
        else $error("disabled channel result carries data");

endmodule

>>> src/ctm_unit.sv
// Shared 64-bit subtract and compare unit with a registered threshold scaler.
`timescale 1ns / 1ps

module ctm_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  ctm_pkg::unit_ctl_t ctl,
    input  ctm_pkg::time_t     a,
    input  ctm_pkg::time_t     b,
    output ctm_pkg::time_t     lim_ns,
    output ctm_pkg::time_t     diff,
    output logic               gt
);

    logic [ctm_pkg::LIMIT_MS_W+ctm_pkg::SCALE_W-1:0] prod;
    ctm_pkg::time_t lim_reg;
    ctm_pkg::time_t lim_next;

    // A 16 by 20 bit product always fits, so the limit needs no saturation.
    assign prod     = ctl.lim_ms * ctm_pkg::NS_PER_MS;
    assign lim_next = ctl.lim_load
                    ? {{(ctm_pkg::TIME_W-ctm_pkg::LIMIT_MS_W-ctm_pkg::SCALE_W){1'b0}}, prod}
                    : lim_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lim_reg <= '0;
        end
        else
        begin
            lim_reg <= lim_next;
        end
    end

    assign lim_ns = lim_reg;
    assign diff   = a - b;
    assign gt     = a > b;

endmodule

>>> bench/channel_timeout_monitor_tb.sv
// Self-checking testbench for the channel timeout monitor: directed and random traffic.
`timescale 1ns / 1ps

module channel_timeout_monitor_tb;

    typedef ctm_pkg::time_t time_t;

    localparam int CHAN_W     = ctm_pkg::CHAN_W;
    localparam int STATUS_W   = ctm_pkg::STATUS_W;
    localparam int LIMIT_MS_W = ctm_pkg::LIMIT_MS_W;
    localparam int TIME_W     = ctm_pkg::TIME_W;
    localparam int CFG_IDX_W  = ctm_pkg::CFG_IDX_W;

    localparam logic REQ_ARRIVAL = ctm_pkg::REQ_ARRIVAL;
    localparam logic REQ_CHECK   = ctm_pkg::REQ_CHECK;

    localparam logic [STATUS_W-1:0] ST_NORMAL  = ctm_pkg::ST_NORMAL;
    localparam logic [STATUS_W-1:0] ST_WARNING = ctm_pkg::ST_WARNING;
    localparam logic [STATUS_W-1:0] ST_ERROR   = ctm_pkg::ST_ERROR;

    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE    = ctm_pkg::CFG_ENABLE;
    localparam logic [CFG_IDX_W-1:0] CFG_WARN_LIM  = ctm_pkg::CFG_WARN_LIM;
    localparam logic [CFG_IDX_W-1:0] CFG_ERROR_LIM = ctm_pkg::CFG_ERROR_LIM;

    localparam int    NCH           = 4;
    localparam int    SETTLE_CYCLES = 4 * NCH + 4;
    localparam int    TOTAL_ITEMS   = 350;
    localparam int    PHASE_ITEMS   = 40;
    localparam time_t MS_NS         = time_t'(ctm_pkg::NS_PER_MS);
    localparam time_t T0            = 64'd1_000_000_000;

    typedef struct {
        logic              req_type;
        logic [CHAN_W-1:0] chan;
        time_t             time_ns;
    } watch_req_t;

    typedef struct {
        logic [CHAN_W-1:0]   out_chan;
        logic [STATUS_W-1:0] status;
        logic                changed;
        time_t               age_ns;
        logic                enabled;
        logic                last;
    } status_beat_t;

    typedef enum int {RX_ALWAYS, RX_LIGHT, RX_PATTERN, RX_HEAVY} rx_mode_t;

    logic clk;
    logic rst_n;

    ctm_req_if req_ch();
    ctm_rsp_if rsp_ch();
    ctm_cfg_if cfg_ch();

    channel_timeout_monitor #(
        .NUM_CHANNELS(NCH)
    ) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    // Shadow of the watchdog: configuration and per-channel history.
    logic [NCH-1:0]      mon_enable;
    time_t               warn_ms_word;
    time_t               error_ms_word;
    time_t               seen_at [NCH];
    logic [STATUS_W-1:0] status_now [NCH];
    logic [STATUS_W-1:0] status_before [NCH];
    time_t               age_now [NCH];

    watch_req_t   requests_to_send [$];
    status_beat_t status_beats_due [$];
    watch_req_t   on_wire;
    status_beat_t beat_due;

    time_t    clock_ns;
    int       work_items;
    int       requests_taken;
    int       checks_taken;
    int       beats_checked;
    int       mismatches;
    int       settings_applied;
    int       warning_beats;
    int       error_beats;
    int       change_beats;
    int       burst_left;
    int       gap_left;
    int       rx_left;
    rx_mode_t rx_mode;
    logic [15:0] rx_pattern;

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    function automatic time_t rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic time_t limit_ns(input time_t word, input int c);
        return time_t'(word[c * LIMIT_MS_W +: LIMIT_MS_W]) * MS_NS;
    endfunction

    function automatic time_t pack_ms(input int unsigned c3, input int unsigned c2,
                                      input int unsigned c1, input int unsigned c0);
        return {c3[15:0], c2[15:0], c1[15:0], c0[15:0]};
    endfunction

    // Mostly small limits so that random ages land on every status; wide ones now and then.
    function automatic time_t random_limits(input bit wide);
        time_t word;
        word = '0;
        for (int c = 0; c < NCH; c++)
            word[c * LIMIT_MS_W +: LIMIT_MS_W] = (wide || $urandom_range(0, 3) == 0)
                ? LIMIT_MS_W'($urandom_range(0, 65535)) : LIMIT_MS_W'($urandom_range(0, 20));
        return word;
    endfunction

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= 40)
            $display("%0t ns  mismatch: %s", $time, what);
    endtask

    // Updates the shadow state for one accepted request and queues the status beats it causes.
    task automatic track_request(input watch_req_t r);
        status_beat_t beat;
        time_t        age;
        logic         on;
        if (r.req_type == REQ_ARRIVAL)
        begin
            if (r.chan < NCH && mon_enable[r.chan])
                seen_at[r.chan] = r.time_ns;
            return;
        end
        for (int c = 0; c < NCH; c++)
        begin
            on = mon_enable[c];
            if (on)
            begin
                if (seen_at[c] != '0)
                begin
                    age = (r.time_ns > seen_at[c]) ? r.time_ns - seen_at[c] : '0;
                    status_before[c] = status_now[c];
                    age_now[c] = age;
                    if (age > limit_ns(error_ms_word, c))
                        status_now[c] = ST_ERROR;
                    else if (age > limit_ns(warn_ms_word, c))
                        status_now[c] = ST_WARNING;
                    else
                        status_now[c] = ST_NORMAL;
                end
                else
                begin
                    // A channel with no history starts its clock at this check.
                    seen_at[c] = r.time_ns;
                    age_now[c] = '0;
                end
            end
            beat.out_chan = CHAN_W'(c);
            beat.status   = on ? status_now[c] : ST_NORMAL;
            beat.changed  = on && (status_now[c] != status_before[c]);
            beat.age_ns   = on ? age_now[c] : '0;
            beat.enabled  = on;
            beat.last     = (c == NCH - 1);
            status_beats_due.push_back(beat);
        end
    endtask

    task automatic queue_request(input logic kind, input logic [CHAN_W-1:0] ch, input time_t t);
        watch_req_t r;
        r.req_type = kind;
        r.chan     = ch;
        r.time_ns  = t;
        requests_to_send.push_back(r);
        work_items++;
    endtask

    // Picks an arrival time for channel c so that the next check sees an age around its limits.
    function automatic time_t arrival_for(input int c);
        time_t w;
        time_t e;
        time_t top;
        time_t age;
        w   = limit_ns(warn_ms_word, c);
        e   = limit_ns(error_ms_word, c);
        top = (w > e) ? w : e;
        age = '0;
        case ($urandom_range(0, 11))
            0:  age = '0;
            1:  age = w;
            2:  age = w + 1;
            3:  age = e;
            4:  age = e + 1;
            5:  age = (w == '0) ? '0 : w - 1;
            6:  age = (e == '0) ? '0 : e - 1;
            7:  age = rand64() % (top + 1);
            8:  age = rand64() % (2 * top + 2);
            9:  return clock_ns + 1 + time_t'($urandom);
            10: return '0;
            default: return rand64();
        endcase
        return clock_ns - age;
    endfunction

    // One round of well-formed traffic: arrivals on some channels, then a check.
    // Now and then the round is replaced by a few requests of pure noise.
    task automatic queue_round();
        time_t widest;
        time_t lim;
        int    first;
        widest = '0;
        for (int c = 0; c < NCH; c++)
        begin
            lim = limit_ns(warn_ms_word, c);
            if (lim > widest)
                widest = lim;
            lim = limit_ns(error_ms_word, c);
            if (lim > widest)
                widest = lim;
        end
        if ($urandom_range(0, 9) == 0)
        begin
            repeat ($urandom_range(1, 3))
                queue_request($urandom_range(0, 1) ? REQ_CHECK : REQ_ARRIVAL,
                              CHAN_W'($urandom_range(0, 3)), rand64());
            return;
        end
        if ($urandom_range(0, 19) == 0)
            clock_ns = ~time_t'($urandom_range(0, 1_000_000_000));
        else
            clock_ns = clock_ns + 1 + rand64() % (2 * widest + 4 * MS_NS);
        first = $urandom_range(0, NCH - 1);
        for (int k = 0; k < NCH; k++)
            if ($urandom_range(0, 3) != 0)
                queue_request(REQ_ARRIVAL, CHAN_W'((first + k) % NCH),
                              arrival_for((first + k) % NCH));
        queue_request(REQ_CHECK, CHAN_W'($urandom_range(0, 3)), clock_ns);
        if ($urandom_range(0, 3) == 0)
            queue_request(REQ_CHECK, CHAN_W'($urandom_range(0, 3)),
                          clock_ns + rand64() % (widest + 2));
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input time_t value);
        @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do
            @(posedge clk);
        while (!(cfg_ch.valid && cfg_ch.ready));
        case (idx)
            CFG_ENABLE:    mon_enable    = value[NCH-1:0];
            CFG_WARN_LIM:  warn_ms_word  = value;
            CFG_ERROR_LIM: error_ms_word = value;
            default:       ;
        endcase
        cfg_ch.valid <= 1'b0;
    endtask

    // Writes all three registers; the enable word carries random upper bits.
    task automatic apply_setting(input logic [NCH-1:0] en, input time_t warn, input time_t err);
        time_t junk;
        junk = rand64();
        write_register(CFG_ENABLE, {junk[TIME_W-1:NCH], en});
        write_register(CFG_WARN_LIM, warn);
        write_register(CFG_ERROR_LIM, err);
        settings_applied++;
        @(negedge clk);
    endtask

    // Holds until every queued request is taken and every status beat has come back,
    // then lets the block finish whatever it may still be doing.
    task automatic wait_until_quiet();
        do
            @(negedge clk);
        while (requests_to_send.size() != 0 || req_ch.valid || status_beats_due.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Request driver: bursts of random length separated by random gaps.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_ch.valid    <= 1'b0;
            req_ch.req_type <= REQ_ARRIVAL;
            req_ch.chan     <= '0;
            req_ch.time_ns  <= '0;
            burst_left = 0;
            gap_left   = 0;
        end
        else
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                track_request(on_wire);
                requests_taken++;
                if (on_wire.req_type == REQ_CHECK)
                    checks_taken++;
            end
            if (!req_ch.valid || req_ch.ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    req_ch.valid <= 1'b0;
                end
                else if (requests_to_send.size() == 0)
                    req_ch.valid <= 1'b0;
                else
                begin
                    on_wire = requests_to_send.pop_front();
                    req_ch.valid    <= 1'b1;
                    req_ch.req_type <= on_wire.req_type;
                    req_ch.chan     <= on_wire.chan;
                    req_ch.time_ns  <= on_wire.time_ns;
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        burst_left = $urandom_range(1, 20);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
            end
        end
    end

    // Status monitor: compares each beat with the oldest prediction and drives a stall pattern.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
            rx_left = 0;
        end
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (status_beats_due.size() == 0)
                    report_mismatch($sformatf("status beat for channel %0d with nothing due",
                                              rsp_ch.out_chan));
                else
                begin
                    beat_due = status_beats_due.pop_front();
                    beats_checked++;
                    if (rsp_ch.out_chan !== beat_due.out_chan)
                        report_mismatch($sformatf("out_chan %0d, wanted %0d",
                                                  rsp_ch.out_chan, beat_due.out_chan));
                    if (rsp_ch.status !== beat_due.status)
                        report_mismatch($sformatf("channel %0d status %0d, wanted %0d",
                                                  beat_due.out_chan, rsp_ch.status,
                                                  beat_due.status));
                    if (rsp_ch.changed !== beat_due.changed)
                        report_mismatch($sformatf("channel %0d changed %0b, wanted %0b",
                                                  beat_due.out_chan, rsp_ch.changed,
                                                  beat_due.changed));
                    if (rsp_ch.age_ns !== beat_due.age_ns)
                        report_mismatch($sformatf("channel %0d age %0d, wanted %0d",
                                                  beat_due.out_chan, rsp_ch.age_ns,
                                                  beat_due.age_ns));
                    if (rsp_ch.enabled !== beat_due.enabled)
                        report_mismatch($sformatf("channel %0d enabled %0b, wanted %0b",
                                                  beat_due.out_chan, rsp_ch.enabled,
                                                  beat_due.enabled));
                    if (rsp_ch.last !== beat_due.last)
                        report_mismatch($sformatf("channel %0d last %0b, wanted %0b",
                                                  beat_due.out_chan, rsp_ch.last,
                                                  beat_due.last));
                    if (beat_due.status == ST_WARNING)
                        warning_beats++;
                    if (beat_due.status == ST_ERROR)
                        error_beats++;
                    if (beat_due.changed)
                        change_beats++;
                end
            end
            if (rx_left == 0)
            begin
                rx_mode    = rx_mode_t'($urandom_range(0, 3));
                rx_left    = $urandom_range(8, 80);
                rx_pattern = 16'($urandom);
            end
            rx_left--;
            case (rx_mode)
                RX_ALWAYS: rsp_ch.ready <= 1'b1;
                RX_LIGHT:  rsp_ch.ready <= ($urandom_range(0, 3) != 0);
                RX_PATTERN:
                begin
                    rsp_ch.ready <= rx_pattern[0];
                    rx_pattern = {rx_pattern[0], rx_pattern[15:1]};
                end
                default:   rsp_ch.ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    initial
    begin
        int phase;
        int phase_goal;
        rst_n        = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = CFG_ENABLE;
        cfg_ch.data  = '0;
        mon_enable    = '0;
        warn_ms_word  = '0;
        error_ms_word = '0;
        for (int c = 0; c < NCH; c++)
        begin
            seen_at[c]       = '0;
            status_now[c]    = ST_NORMAL;
            status_before[c] = ST_NORMAL;
            age_now[c]       = '0;
        end
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Straight out of reset every channel is off.
        queue_request(REQ_CHECK, 2'd0, 64'd5000);
        wait_until_quiet();

        // Warning limits 1..4 ms and error limits 5..8 ms, channel 0 lowest.
        apply_setting(4'hF, pack_ms(4, 3, 2, 1), pack_ms(8, 7, 6, 5));
        queue_request(REQ_CHECK, 2'd0, 64'd1000);
        for (int c = 0; c < NCH; c++)
            queue_request(REQ_ARRIVAL, CHAN_W'(c), T0);
        // Age exactly on the channel 0 warning limit stays normal.
        queue_request(REQ_CHECK, 2'd1, T0 + MS_NS);
        queue_request(REQ_CHECK, 2'd2, T0 + 3 * MS_NS);
        queue_request(REQ_CHECK, 2'd0, T0 + 5 * MS_NS + 1);
        // A timestamp in the future, a zero timestamp and the largest timestamp.
        queue_request(REQ_ARRIVAL, 2'd1, T0 + 64'd10_000_000_000);
        queue_request(REQ_ARRIVAL, 2'd2, '0);
        queue_request(REQ_ARRIVAL, 2'd3, '1);
        queue_request(REQ_CHECK, 2'd3, T0 + 8 * MS_NS + 1);
        queue_request(REQ_CHECK, 2'd1, '1);
        queue_request(REQ_CHECK, 2'd2, '0);
        wait_until_quiet();

        // Odd channels off; their history must survive until they come back.
        apply_setting(4'h5, '0, '1);
        queue_request(REQ_ARRIVAL, 2'd1, 64'd123);
        queue_request(REQ_ARRIVAL, 2'd0, 64'd1);
        queue_request(REQ_CHECK, 2'd0, '1);
        wait_until_quiet();

        // Error limit below the warning limit: the error test wins.
        apply_setting(4'hF, '1, '0);
        queue_request(REQ_CHECK, 2'd0, 64'd20_000_000_000);
        queue_request(REQ_ARRIVAL, 2'd3, 64'h8000_0000_0000_0000);
        queue_request(REQ_CHECK, 2'd3, 64'h8000_0000_0000_0000 + 65535 * MS_NS);

        // Random part: one register setting per phase, draining before each change.
        clock_ns = rand64() >> 8;
        phase = 0;
        while (work_items < TOTAL_ITEMS)
        begin
            wait_until_quiet();
            case (phase)
                0:       apply_setting(4'hF, random_limits(1'b0), random_limits(1'b0));
                1:       apply_setting(4'h0, random_limits(1'b1), random_limits(1'b1));
                2:       apply_setting(NCH'($urandom_range(1, 15)), '0, '0);
                3:       apply_setting(4'hF, '1, '1);
                4:       apply_setting(4'hF, pack_ms(20, 20, 20, 20), pack_ms(3, 7, 1, 0));
                default: apply_setting(NCH'($urandom_range(0, 15)),
                                       random_limits($urandom_range(0, 3) == 0),
                                       random_limits($urandom_range(0, 3) == 0));
            endcase
            phase_goal = work_items + PHASE_ITEMS;
            while (work_items < phase_goal)
                queue_round();
            phase++;
        end
        wait_until_quiet();

        if (status_beats_due.size() != 0)
            report_mismatch($sformatf("%0d status beats never arrived", status_beats_due.size()));
        $display("Run covered %0d requests (%0d checks) over %0d register settings.",
                 requests_taken, checks_taken, settings_applied);
        $display("Compared %0d status beats: %0d warning, %0d error, %0d with a status change.",
                 beats_checked, warning_beats, error_beats, change_beats);
        if (mismatches == 0)
            $display("[channel_timeout_monitor] OK");
        else
            $display("[channel_timeout_monitor] ERROR");
        $finish;
    end

    // Watchdog on the bench itself: far beyond the slowest legal run.
    initial
    begin
        #3_000_000;
        $display("[channel_timeout_monitor] ERROR");
        $finish;
    end

endmodule

>>> files.f
src/ctm_pkg.sv
src/ctm_intf.sv
src/ctm_unit.sv
src/channel_timeout_monitor.sv
bench/channel_timeout_monitor_tb.sv
